// ===== src/vxdc_pkg.sv =====
// shared types and constants for the vxlan decapsulation classifier
`timescale 1ns / 1ps
package vxdc_pkg;
  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAX_FRAME_BYTES_DEF = 16383;
  localparam int HDR_BYTES = 16;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ = 2'd2
  } action_t;

  typedef enum logic [5:0] {
    PH_ETH = 6'b000001,
    PH_VLAN = 6'b000010,
    PH_IP = 6'b000100,
    PH_UDP = 6'b001000,
    PH_VXLAN = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] pkt_byte;
    logic last_byte;
    logic [3:0] entry_index;
    logic [31:0] key_addr;
    logic [15:0] key_port;
    logic [31:0] key_vni;
    logic [31:0] out_ifindex;
    logic entry_valid;
  } in_item_t;

  typedef struct packed {
    logic result_kind;
    logic redirect;
    logic [31:0] redirect_ifindex;
    logic [3:0] hit_index;
    logic [13:0] strip_offset;
    logic [63:0] packet_total;
    logic [63:0] byte_total;
  } out_item_t;

  // parsed frame handed from the parser to the classifier
  typedef struct packed {
    logic ok;
    logic [31:0] addr;
    logic [15:0] port;
    logic [31:0] vni;
    logic [16:0] strip;
    logic [16:0] payload;
  } frame_info_t;
endpackage

// ===== src/vxdc_parser.sv =====
// byte-serial header parser for ethernet, ipv4, udp and vxlan
`timescale 1ns / 1ps
module vxdc_parser #(
  parameter int MAX_FRAME_BYTES = vxdc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic byte_en,
  input  logic [7:0] pkt_byte,
  input  logic last_byte,
  output vxdc_pkg::frame_info_t info
);
  localparam int PW = $clog2(MAX_FRAME_BYTES + 2);

  logic [PW-1:0] pos, pos_next;
  vxdc_pkg::phase_t phase, phase_next;
  logic failed, failed_next;
  logic [15:0] etype, etype_next;
  logic [5:0] ihl, ihl_next;
  logic [7:0] proto, proto_next;
  logic [31:0] daddr, daddr_next;
  logic [15:0] dport, dport_next;
  logic [15:0] ulen, ulen_next;
  logic [PW-1:0] ustart, ustart_next;
  logic [31:0] flags, flags_next;
  logic [31:0] vni, vni_next;
  logic [PW-1:0] seg, seg_next;
  logic [PW-1:0] rel, urel, len;

  always_comb begin
    pos_next = pos; phase_next = phase; failed_next = failed; etype_next = etype;
    ihl_next = ihl; proto_next = proto; daddr_next = daddr; dport_next = dport;
    ulen_next = ulen; ustart_next = ustart; flags_next = flags; vni_next = vni;
    seg_next = seg;
    rel = pos - seg;
    urel = pos - ustart;
    if (!failed && phase != vxdc_pkg::PH_DONE && pos <= PW'(MAX_FRAME_BYTES)) begin
      unique case (phase)
        vxdc_pkg::PH_ETH: begin
          if (pos == PW'(12)) etype_next = {pkt_byte, 8'h00};
          if (pos == PW'(13)) begin
            seg_next = PW'(14);
            if ({etype[15:8], pkt_byte} == 16'h8100 || {etype[15:8], pkt_byte} == 16'h88A8)
              phase_next = vxdc_pkg::PH_VLAN;
            else if ({etype[15:8], pkt_byte} == 16'h0800) phase_next = vxdc_pkg::PH_IP;
            else failed_next = 1'b1;
            etype_next = {etype[15:8], pkt_byte};
          end
        end
        vxdc_pkg::PH_VLAN: begin
          if (rel == PW'(2)) etype_next = {pkt_byte, 8'h00};
          if (rel == PW'(3)) begin
            etype_next = {etype[15:8], pkt_byte};
            seg_next = PW'(18);
            if ({etype[15:8], pkt_byte} == 16'h0800) phase_next = vxdc_pkg::PH_IP;
            else failed_next = 1'b1;
          end
        end
        vxdc_pkg::PH_IP: begin
          if (rel == '0) begin
            ihl_next = {pkt_byte[3:0], 2'b00};
            if (pkt_byte[3:0] < 4'd5) failed_next = 1'b1;
          end else if (rel == PW'(9)) begin
            proto_next = pkt_byte;
          end else if (rel >= PW'(16) && rel <= PW'(19)) begin
            daddr_next = {daddr[23:0], pkt_byte};
            if (rel == PW'(19)) begin
              if (proto != 8'd17) failed_next = 1'b1;
              else begin
                ustart_next = seg + PW'(ihl);
                phase_next = vxdc_pkg::PH_UDP;
              end
            end
          end
        end
        vxdc_pkg::PH_UDP: begin
          if (pos >= ustart) begin
            if (urel == PW'(2) || urel == PW'(3)) dport_next = {dport[7:0], pkt_byte};
            else if (urel == PW'(4) || urel == PW'(5)) ulen_next = {ulen[7:0], pkt_byte};
            else if (urel == PW'(6) || urel == PW'(7)) begin
              if (pkt_byte != 8'd0) failed_next = 1'b1;
              else if (urel == PW'(7) && !failed) begin
                if (ulen < 16'd8) failed_next = 1'b1;
                else phase_next = vxdc_pkg::PH_VXLAN;
              end
            end
          end
        end
        vxdc_pkg::PH_VXLAN: begin
          if (urel >= PW'(8) && urel <= PW'(11)) flags_next = {flags[23:0], pkt_byte};
          else if (urel >= PW'(12) && urel <= PW'(15)) begin
            vni_next = {vni[23:0], pkt_byte};
            if (urel == PW'(15)) phase_next = vxdc_pkg::PH_DONE;
          end
        end
        default: failed_next = 1'b1;
      endcase
    end
    if (pos <= PW'(MAX_FRAME_BYTES)) pos_next = pos + PW'(1);
    len = pos_next;
    info.ok = !failed_next && phase_next == vxdc_pkg::PH_DONE
              && len <= PW'(MAX_FRAME_BYTES)
              && 17'(ulen_next) <= 17'(len - ustart_next)
              && flags_next == 32'd0 && vni_next != 32'd0;
    info.addr = daddr_next;
    info.port = dport_next;
    info.vni = vni_next;
    info.strip = 17'(ustart_next) + 17'(vxdc_pkg::HDR_BYTES);
    info.payload = 17'(len) - 17'(ustart_next) - 17'(vxdc_pkg::HDR_BYTES);
  end

  always_ff @(posedge clk) begin
    if (rst || (byte_en && last_byte)) begin
      pos <= '0; phase <= vxdc_pkg::PH_ETH; failed <= 1'b0; etype <= '0; ihl <= '0;
      proto <= '0; daddr <= '0; dport <= '0; ulen <= '0; ustart <= '0; flags <= '0;
      vni <= '0; seg <= '0;
    end else if (byte_en) begin
      pos <= pos_next; phase <= phase_next; failed <= failed_next; etype <= etype_next;
      ihl <= ihl_next; proto <= proto_next; daddr <= daddr_next; dport <= dport_next;
      ulen <= ulen_next; ustart <= ustart_next; flags <= flags_next; vni <= vni_next;
      seg <= seg_next;
    end
  end
endmodule

// ===== src/vxlan_decap_classifier.sv =====
// top level: parser, match table with counters, and output register
// a result is registered and appears in the cycle after the transaction that causes it
// throughput: one transaction per cycle while the output is not stalled, the parser and table compare sit in one stage
// the hit counter update is two 64-bit adds in that same stage
// reset: synchronous rst empties the table, clears counters and restarts the parser
`timescale 1ns / 1ps
module vxlan_decap_classifier #(
  parameter int TABLE_ENTRIES = vxdc_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_FRAME_BYTES = vxdc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  vxdc_pkg::in_item_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output vxdc_pkg::out_item_t out_data
);
  logic acc, byte_en, hit;
  logic [3:0] hit_idx;
  vxdc_pkg::frame_info_t info;
  vxdc_pkg::out_item_t res;
  logic [TABLE_ENTRIES-1:0] tvalid;
  logic [31:0] taddr [TABLE_ENTRIES];
  logic [15:0] tport [TABLE_ENTRIES];
  logic [31:0] tvni [TABLE_ENTRIES];
  logic [31:0] tif [TABLE_ENTRIES];
  logic [63:0] tpk [TABLE_ENTRIES];
  logic [63:0] tby [TABLE_ENTRIES];

  assign in_ready = !out_valid || out_ready;
  assign acc = in_valid && in_ready;
  assign byte_en = acc && in_data.action == vxdc_pkg::ACT_BYTE;

  vxdc_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parser (
    .clk(clk), .rst(rst), .byte_en(byte_en), .pkt_byte(in_data.pkt_byte),
    .last_byte(in_data.last_byte), .info(info)
  );

  always_comb begin
    hit = 1'b0;
    hit_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (tvalid[i] && taddr[i] == info.addr && tport[i] == info.port && tvni[i] == info.vni)
      begin
        hit = info.ok;
        hit_idx = 4'(i);
      end
    end
    res = '0;
    if (in_data.action == vxdc_pkg::ACT_READ) begin
      res.result_kind = 1'b1;
      if (32'(in_data.entry_index) < TABLE_ENTRIES) begin
        res.packet_total = tpk[in_data.entry_index];
        res.byte_total = tby[in_data.entry_index];
      end
    end else if (hit) begin
      res.redirect = 1'b1;
      res.redirect_ifindex = tif[hit_idx];
      res.hit_index = hit_idx;
      res.strip_offset = info.strip[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        taddr[i] <= '0; tport[i] <= '0; tvni[i] <= '0; tif[i] <= '0;
        tpk[i] <= '0; tby[i] <= '0;
      end
    end else if (acc) begin
      if (in_data.action == vxdc_pkg::ACT_WRITE && 32'(in_data.entry_index) < TABLE_ENTRIES)
      begin
        tvalid[in_data.entry_index] <= in_data.entry_valid;
        taddr[in_data.entry_index] <= in_data.key_addr;
        tport[in_data.entry_index] <= in_data.key_port;
        tvni[in_data.entry_index] <= in_data.key_vni;
        tif[in_data.entry_index] <= in_data.out_ifindex;
        tpk[in_data.entry_index] <= '0;
        tby[in_data.entry_index] <= '0;
      end else if (byte_en && in_data.last_byte && hit) begin
        tpk[hit_idx] <= tpk[hit_idx] + 64'd1;
        tby[hit_idx] <= tby[hit_idx] + 64'(info.payload);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= in_data.action == vxdc_pkg::ACT_READ || (byte_en && in_data.last_byte);
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) out_data <= res;
  end
endmodule

// ===== src/vxdc_checker.sv =====
// port-level checks for the classifier, bound to the top level
`timescale 1ns / 1ps
module vxdc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input vxdc_pkg::in_item_t in_data,
  input logic out_valid,
  input logic out_ready,
  input vxdc_pkg::out_item_t out_data
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.action == vxdc_pkg::ACT_READ |=>
    out_valid && out_data.result_kind)
    else $error("readout transaction missing");
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.action == vxdc_pkg::ACT_WRITE |=> !out_valid)
    else $error("table write produced a result");
  a_readout_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind |-> !out_data.redirect && out_data.strip_offset == '0)
    else $error("readout carries verdict fields");
endmodule

bind vxlan_decap_classifier vxdc_checker u_vxdc_checker (.*);

// ===== bench/vxlan_decap_classifier_tb.sv =====
// self-checking bench for the vxlan decapsulation classifier: random frames, table writes, readouts
`timescale 1ns / 1ps
module vxlan_decap_classifier_tb;

  localparam int NENT = 16;
  localparam int MAXF = 16383;
  localparam int CYCLE_LIMIT = 2000000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  vxdc_pkg::in_item_t in_data;
  logic out_valid;
  logic out_ready;
  vxdc_pkg::out_item_t out_data;

  vxlan_decap_classifier dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // predictor state
  int unsigned pos;
  int unsigned phase;
  bit failed;
  logic [15:0] etype;
  int unsigned ihl;
  logic [7:0] proto;
  logic [31:0] daddr;
  logic [15:0] dport;
  logic [15:0] ulen;
  int unsigned ustart;
  logic [31:0] vflags;
  logic [31:0] vni;
  int unsigned seg;
  bit tv[NENT];
  logic [31:0] taddr[NENT];
  logic [15:0] tport[NENT];
  logic [31:0] tvni[NENT];
  logic [31:0] tif[NENT];
  logic [63:0] tpk[NENT];
  logic [63:0] tby[NENT];

  vxdc_pkg::in_item_t pending_items[$];
  vxdc_pkg::out_item_t expected_results[$];
  int mismatches;
  int cycles;
  bit hold_off;
  int burst_left;
  int gap_left;
  int stall_phase;

  localparam int P_ETH = 0, P_VLAN = 1, P_IP = 2, P_UDP = 3, P_VX = 4, P_DONE = 5;

  task automatic restart_parser();
    pos = 0; phase = P_ETH; failed = 0; etype = 0; ihl = 0; proto = 0; daddr = 0;
    dport = 0; ulen = 0; ustart = 0; vflags = 0; vni = 0; seg = 0;
  endtask

  task automatic parse_one(input int unsigned p, input logic [7:0] b);
    int unsigned rel;
    if (failed || phase == P_DONE || p > MAXF) return;
    case (phase)
      P_ETH: begin
        if (p == 12) etype = {b, 8'h00};
        if (p == 13) begin
          etype[7:0] = b; seg = 14;
          if (etype == 16'h8100 || etype == 16'h88a8) phase = P_VLAN;
          else if (etype == 16'h0800) phase = P_IP;
          else failed = 1;
        end
      end
      P_VLAN: begin
        rel = p - seg;
        if (rel == 2) etype = {b, 8'h00};
        if (rel == 3) begin
          etype[7:0] = b; seg = 18;
          if (etype == 16'h0800) phase = P_IP;
          else failed = 1;
        end
      end
      P_IP: begin
        rel = p - seg;
        if (rel == 0) begin
          ihl = (b & 15) << 2;
          if (ihl < 20) failed = 1;
        end else if (rel == 9) proto = b;
        else if (rel >= 16 && rel <= 19) begin
          daddr = {daddr[23:0], b};
          if (rel == 19) begin
            if (proto != 17) failed = 1;
            else begin
              ustart = seg + ihl; phase = P_UDP;
            end
          end
        end
      end
      P_UDP: begin
        if (p >= ustart) begin
          rel = p - ustart;
          if (rel == 2 || rel == 3) dport = {dport[7:0], b};
          else if (rel == 4 || rel == 5) ulen = {ulen[7:0], b};
          else if (rel == 6 || rel == 7) begin
            if (b != 0) failed = 1;
            if (rel == 7 && !failed) begin
              if (ulen < 8) failed = 1;
              else phase = P_VX;
            end
          end
        end
      end
      P_VX: begin
        rel = p - ustart;
        if (rel >= 8 && rel <= 11) vflags = {vflags[23:0], b};
        else if (rel >= 12 && rel <= 15) begin
          vni = {vni[23:0], b};
          if (rel == 15) phase = P_DONE;
        end
      end
      default: failed = 1;
    endcase
  endtask

  task automatic classify_item(input vxdc_pkg::in_item_t it);
    vxdc_pkg::out_item_t r;
    int unsigned len;
    int unsigned strip;
    bit ok;
    r = '0;
    if (it.action == vxdc_pkg::ACT_WRITE) begin
      tv[it.entry_index] = it.entry_valid; taddr[it.entry_index] = it.key_addr;
      tport[it.entry_index] = it.key_port; tvni[it.entry_index] = it.key_vni;
      tif[it.entry_index] = it.out_ifindex;
      tpk[it.entry_index] = 0; tby[it.entry_index] = 0;
      return;
    end
    if (it.action == vxdc_pkg::ACT_READ) begin
      r.result_kind = 1;
      r.packet_total = tpk[it.entry_index]; r.byte_total = tby[it.entry_index];
      expected_results.push_back(r);
      return;
    end
    if (it.action != vxdc_pkg::ACT_BYTE) return;
    parse_one(pos, it.pkt_byte);
    if (pos <= MAXF) pos++;
    if (!it.last_byte) return;
    len = pos;
    ok = !failed && phase == P_DONE && len <= MAXF && ulen <= len - ustart
         && vflags == 0 && vni != 0;
    if (ok) begin
      for (int i = 0; i < NENT; i++) begin
        if (tv[i] && taddr[i] == daddr && tport[i] == dport && tvni[i] == vni) begin
          strip = ustart + 16;
          tpk[i] += 1; tby[i] += 64'(len - strip);
          r.redirect = 1; r.redirect_ifindex = tif[i]; r.hit_index = i[3:0];
          r.strip_offset = strip[13:0];
          break;
        end
      end
    end
    restart_parser();
    expected_results.push_back(r);
  endtask

  // key pool so frames hit often
  logic [31:0] pool_addr[4];
  logic [15:0] pool_port[4];
  logic [31:0] pool_vni[4];

  function automatic vxdc_pkg::in_item_t blank_item(input vxdc_pkg::action_t a);
    vxdc_pkg::in_item_t it;
    it = '0;
    it.action = a;
    it.key_addr = $urandom; it.key_port = 16'($urandom); it.key_vni = $urandom;
    it.out_ifindex = $urandom; it.entry_valid = 1'($urandom);
    it.entry_index = 4'($urandom);
    return it;
  endfunction

  task automatic queue_write(input int idx, input logic [31:0] a, input logic [15:0] p,
                             input logic [31:0] v, input logic [31:0] ifx, input bit val);
    vxdc_pkg::in_item_t it;
    it = blank_item(vxdc_pkg::ACT_WRITE);
    it.entry_index = idx[3:0]; it.key_addr = a; it.key_port = p; it.key_vni = v;
    it.out_ifindex = ifx; it.entry_valid = val;
    pending_items.push_back(it);
  endtask

  task automatic queue_read(input int idx);
    vxdc_pkg::in_item_t it;
    it = blank_item(vxdc_pkg::ACT_READ);
    it.entry_index = idx[3:0];
    pending_items.push_back(it);
  endtask

  task automatic queue_bytes(input logic [7:0] fr[$]);
    vxdc_pkg::in_item_t it;
    foreach (fr[i]) begin
      it = blank_item(vxdc_pkg::ACT_BYTE);
      it.pkt_byte = fr[i];
      it.last_byte = (i == fr.size() - 1);
      pending_items.push_back(it);
    end
  endtask

  // builds a vxlan frame; corrupt selects one defect (0 none)
  task automatic build_frame(output logic [7:0] fr[$], input int corrupt, input int tag,
                             input logic [31:0] a, input logic [15:0] p, input logic [31:0] v,
                             input int opts, input int payload);
    int hl;
    int ul;
    fr = {};
    repeat (12) fr.push_back(8'($urandom));
    if (tag == 1) begin
      fr.push_back(8'h81); fr.push_back(8'h00);
    end else if (tag == 2) begin
      fr.push_back(8'h88); fr.push_back(8'ha8);
    end
    if (tag != 0) begin
      fr.push_back(8'($urandom)); fr.push_back(8'($urandom));
    end
    if (corrupt == 1) begin
      fr.push_back(8'h86); fr.push_back(8'hdd);
    end else begin
      fr.push_back(8'h08); fr.push_back(8'h00);
    end
    hl = 5 + opts;
    fr.push_back(corrupt == 2 ? 8'h43 : {4'h4, 4'(hl)});
    repeat (8) fr.push_back(8'($urandom));
    fr.push_back(corrupt == 3 ? 8'd6 : 8'd17);
    repeat (6) fr.push_back(8'($urandom));
    fr.push_back(a[31:24]); fr.push_back(a[23:16]); fr.push_back(a[15:8]); fr.push_back(a[7:0]);
    repeat (opts * 4) fr.push_back(8'($urandom));
    ul = 16 + payload;
    if (corrupt == 4) ul = ul + 1 + $urandom_range(0, 40);
    if (corrupt == 5) ul = $urandom_range(0, 7);
    fr.push_back(8'($urandom)); fr.push_back(8'($urandom));
    fr.push_back(p[15:8]); fr.push_back(p[7:0]);
    fr.push_back(ul[15:8]); fr.push_back(ul[7:0]);
    fr.push_back(8'h00); fr.push_back(corrupt == 6 ? 8'(1 + $urandom_range(0, 254)) : 8'h00);
    if (corrupt == 7) begin
      fr.push_back(8'h08); fr.push_back(8'h00); fr.push_back(8'h00); fr.push_back(8'h00);
    end else repeat (4) fr.push_back(8'h00);
    if (corrupt == 8) repeat (4) fr.push_back(8'h00);
    else begin
      fr.push_back(v[31:24]); fr.push_back(v[23:16]); fr.push_back(v[15:8]); fr.push_back(v[7:0]);
    end
    repeat (payload) fr.push_back(8'($urandom));
    if (corrupt == 9) fr = fr[0:$urandom_range(0, fr.size() - 2)];
  endtask

  task automatic queue_random_frame(input int corrupt);
    logic [7:0] fr[$];
    int k;
    logic [31:0] v;
    k = $urandom_range(0, 3);
    v = pool_vni[k];
    build_frame(fr, corrupt, $urandom_range(0, 2),
                ($urandom_range(0, 9) == 0) ? $urandom : pool_addr[k], pool_port[k], v,
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0,
                $urandom_range(0, 12));
    queue_bytes(fr);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 0;
      end else if (!hold_off && pending_items.size() > 0) begin
        in_data <= pending_items[0];
        classify_item(pending_items.pop_front());
        in_valid <= 1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else burst_left <= burst_left - 1;
      end else in_valid <= 0;
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      out_ready <= (stall_phase % 256 < 64) ? 1'b1 : ((stall_phase % 7) < 4);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: %p", out_data);
        end else begin
          vxdc_pkg::out_item_t e;
          e = expected_results.pop_front();
          if (e != out_data) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] fr[$];
    vxdc_pkg::in_item_t it;
    rst = 1; in_valid = 0; in_data = '0; out_ready = 0; cycles = 0; mismatches = 0;
    hold_off = 0; stall_phase = 0;
    for (int i = 0; i < NENT; i++) begin
      tv[i] = 0; taddr[i] = 0; tport[i] = 0; tvni[i] = 0; tif[i] = 0; tpk[i] = 0; tby[i] = 0;
    end
    restart_parser();
    for (int i = 0; i < 4; i++) begin
      pool_addr[i] = $urandom; pool_port[i] = 16'($urandom); pool_vni[i] = $urandom | 1;
    end
    pool_addr[0] = '1; pool_port[0] = '1; pool_vni[0] = '1;
    repeat (6) @(posedge clk);
    rst <= 0;

    // directed part
    queue_write(0, pool_addr[0], pool_port[0], pool_vni[0], 32'hffffffff, 1);
    queue_write(15, pool_addr[1], pool_port[1], pool_vni[1], 32'h0, 1);
    queue_write(3, pool_addr[1], pool_port[1], pool_vni[1], 32'h5, 1);
    queue_write(7, pool_addr[2], pool_port[2], pool_vni[2], 32'h7, 0);
    build_frame(fr, 0, 0, pool_addr[0], pool_port[0], pool_vni[0], 0, 4); queue_bytes(fr);
    build_frame(fr, 0, 1, pool_addr[1], pool_port[1], pool_vni[1], 10, 0); queue_bytes(fr);
    build_frame(fr, 0, 2, pool_addr[2], pool_port[2], pool_vni[2], 0, 2); queue_bytes(fr);
    for (int c = 1; c <= 9; c++) begin
      build_frame(fr, c, 0, pool_addr[0], pool_port[0], pool_vni[0], 0, 3); queue_bytes(fr);
    end
    it = blank_item(vxdc_pkg::ACT_BYTE); it.last_byte = 1; it.pkt_byte = 8'hff;
    pending_items.push_back(it);
    it = blank_item(vxdc_pkg::ACT_BYTE); it.action = 2'd3; pending_items.push_back(it);
    queue_read(0); queue_read(3); queue_read(15); queue_read(7);

    // pause until the block drains
    wait (pending_items.size() == 0);
    hold_off = 1;
    wait (expected_results.size() == 0);
    repeat (3) @(posedge clk);
    hold_off = 0;

    // random part
    for (int n = 0; n < 6; n++) begin
      case ($urandom_range(0, 9))
        0: queue_write($urandom_range(0, 15), pool_addr[$urandom_range(0, 3)],
                       pool_port[$urandom_range(0, 3)], pool_vni[$urandom_range(0, 3)],
                       $urandom, $urandom_range(0, 4) != 0);
        1: queue_read($urandom_range(0, 15));
        2: begin
          it = blank_item(vxdc_pkg::ACT_BYTE);
          it.pkt_byte = 8'($urandom); it.last_byte = 1'($urandom);
          it.action = 2'($urandom);
          pending_items.push_back(it);
        end
        3: queue_random_frame($urandom_range(1, 9));
        default: queue_random_frame(0);
      endcase
      if (n % 10 == 0) wait (pending_items.size() < 50);
    end
    for (int i = 0; i < NENT; i++) queue_read(i);

    wait (pending_items.size() == 0);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
src/vxdc_pkg.sv
src/vxdc_parser.sv
src/vxlan_decap_classifier.sv
src/vxdc_checker.sv
bench/vxlan_decap_classifier_tb.sv
